/* src/mvm_pkg.sv */
package mvm_pkg;

    // fixed field widths
    localparam int ACT_W     = 2;
    localparam int IDX_W     = 6;
    localparam int DIM_W     = 7;
    localparam int OUT_W     = 38;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;

    // parameter defaults
    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 16;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOAD_MATRIX = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_VECTOR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSED = 2'd2;

    // token walking down the cell chain
    typedef struct packed {
        logic             valid;
        logic             accum;   // transposed row pass, accumulate locally
        logic             drain;   // transposed readout of one cell
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;     // row, or cell to read out
    } mvm_tok_t;

    // load bus broadcast to the cells and the vector store
    typedef struct packed {
        logic             mat_we;
        logic             vec_we;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] vidx;
    } mvm_wr_t;

endpackage

/* src/mvm_item_if.sv */
interface mvm_item_if #(
    parameter int VALUE_WIDTH = mvm_pkg::VALUE_WIDTH_DEF
);
    import mvm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [ACT_W-1:0]              action;
    logic [IDX_W-1:0]              row;
    logic [IDX_W-1:0]              col;
    logic [IDX_W-1:0]              vector_index;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (
        output valid, action, row, col, vector_index, value,
        input  ready
    );

    modport sink (
        input  valid, action, row, col, vector_index, value,
        output ready
    );
endinterface

/* src/mvm_result_if.sv */
interface mvm_result_if;
    import mvm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_index;
    logic signed [OUT_W-1:0] out_value;
    logic                    last;

    modport source (
        output valid, out_index, out_value, last,
        input  ready
    );

    modport sink (
        input  valid, out_index, out_value, last,
        output ready
    );
endinterface

/* src/mvm_cell.sv */
module mvm_cell #(
    parameter int MAX_ROWS    = mvm_pkg::MAX_ROWS_DEF,
    parameter int VALUE_WIDTH = mvm_pkg::VALUE_WIDTH_DEF,
    parameter int IDX         = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [mvm_pkg::DIM_W-1:0]     nc_eff,
    input  mvm_pkg::mvm_wr_t              wr,
    input  logic signed [VALUE_WIDTH-1:0] wr_value,
    input  mvm_pkg::mvm_tok_t             tok_in,
    input  logic signed [VALUE_WIDTH-1:0] vec_in,
    input  logic signed [mvm_pkg::OUT_W-1:0] sum_in,
    output mvm_pkg::mvm_tok_t             tok_out,
    output logic signed [VALUE_WIDTH-1:0] vec_out,
    output logic signed [mvm_pkg::OUT_W-1:0] sum_out
);
    import mvm_pkg::*;

    localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PROD_W  = 2 * VALUE_WIDTH;

    // one matrix column lives in this cell
    logic signed [VALUE_WIDTH-1:0] col_mem [MAX_ROWS];

    logic signed [VALUE_WIDTH-1:0] v_reg;
    logic signed [VALUE_WIDTH-1:0] rd_reg;
    logic signed [VALUE_WIDTH-1:0] vec0_reg;
    logic signed [VALUE_WIDTH-1:0] vec1_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [OUT_W-1:0]       acc_reg;
    logic signed [OUT_W-1:0]       acc_next;
    logic signed [OUT_W-1:0]       sum_reg;
    logic signed [OUT_W-1:0]       sum_next;
    logic signed [OUT_W-1:0]       prod_ext;
    logic signed [OUT_W-1:0]       contrib;
    mvm_tok_t                      tok0_reg;
    mvm_tok_t                      tok1_reg;
    mvm_tok_t                      tok2_reg;
    logic                          active;
    logic                          mat_hit;
    logic                          vec_hit;

    assign active  = (DIM_W'(IDX) < nc_eff);
    assign mat_hit = wr.mat_we && (wr.col == IDX_W'(IDX))
                  && ({1'b0, wr.row} < DIM_W'(MAX_ROWS));
    assign vec_hit = wr.vec_we && (wr.vidx == IDX_W'(IDX));

    always_ff @(posedge clk)
    begin
        if (mat_hit)
        begin
            col_mem[wr.row[ROW_AW-1:0]] <= wr_value;
        end
        if (adv)
        begin
            rd_reg <= col_mem[tok0_reg.idx[ROW_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vec_hit)
        begin
            v_reg <= wr_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg <= '0;
            tok1_reg <= '0;
            tok2_reg <= '0;
        end
        else if (adv)
        begin
            tok0_reg <= tok_in;
            tok1_reg <= tok0_reg;
            tok2_reg <= tok1_reg;
        end
    end

    assign prod_ext = OUT_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (tok2_reg.valid && tok2_reg.accum)
        begin
            acc_next = (tok2_reg.first ? '0 : acc_reg) + prod_ext;
        end

        contrib = '0;
        if (tok2_reg.drain)
        begin
            if (tok2_reg.idx == IDX_W'(IDX))
            begin
                contrib = acc_reg;
            end
        end
        else if (!tok2_reg.accum && active)
        begin
            contrib = prod_ext;
        end
        sum_next = sum_in + contrib;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec0_reg <= vec_in;
            vec1_reg <= vec0_reg;
            // transposed rows use the streamed vector element, normal rows our own
            prod_reg <= rd_reg * (tok1_reg.accum ? vec1_reg : v_reg);
            acc_reg  <= acc_next;
            sum_reg  <= sum_next;
        end
    end

    assign tok_out = tok0_reg;
    assign vec_out = vec0_reg;
    assign sum_out = sum_reg;

endmodule

/* src/mvm_seq.sv */
module mvm_seq #(
    parameter int MAX_ROWS    = mvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = mvm_pkg::MAX_COLS_DEF,
    parameter int VALUE_WIDTH = mvm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          start,
    input  logic                          done,
    input  logic                          transposed,
    input  logic [mvm_pkg::DIM_W-1:0]     nr_eff,
    input  logic [mvm_pkg::DIM_W-1:0]     nc_eff,
    input  mvm_pkg::mvm_wr_t              wr,
    input  logic signed [VALUE_WIDTH-1:0] wr_value,
    output logic                          busy,
    output mvm_pkg::mvm_tok_t             tok,
    output logic signed [VALUE_WIDTH-1:0] vec
);
    import mvm_pkg::*;

    localparam int VEC_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int VAW       = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROWS  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_WAIT  = 4'b1000
    } seq_state_t;

    logic signed [VALUE_WIDTH-1:0] vec_mem [VEC_DEPTH];

    seq_state_t                    state_reg;
    seq_state_t                    state_next;
    logic [DIM_W-1:0]              cnt_reg;
    logic [DIM_W-1:0]              cnt_next;
    logic                          mode_reg;
    logic                          mode_next;
    mvm_tok_t                      tok_reg;
    mvm_tok_t                      tok_next;
    logic signed [VALUE_WIDTH-1:0] vec_rd_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        tok_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_ROWS;
                    cnt_next   = '0;
                    mode_next  = transposed;
                end
            end
            S_ROWS:
            begin
                tok_next.valid = 1'b1;
                tok_next.accum = mode_reg;
                tok_next.first = (cnt_reg == '0);
                tok_next.last  = (cnt_reg == nr_eff - DIM_W'(1));
                tok_next.idx   = cnt_reg[IDX_W-1:0];
                if (adv)
                begin
                    if (cnt_reg == nr_eff - DIM_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = mode_reg ? S_DRAIN : S_WAIT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + DIM_W'(1);
                    end
                end
            end
            S_DRAIN:
            begin
                tok_next.valid = 1'b1;
                tok_next.drain = 1'b1;
                tok_next.last  = (cnt_reg == nc_eff - DIM_W'(1));
                tok_next.idx   = cnt_reg[IDX_W-1:0];
                if (adv)
                begin
                    if (cnt_reg == nc_eff - DIM_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + DIM_W'(1);
                    end
                end
            end
            S_WAIT:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            mode_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mode_reg  <= mode_next;
            if (adv)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.vec_we && ({1'b0, wr.vidx} < DIM_W'(VEC_DEPTH)))
        begin
            vec_mem[wr.vidx[VAW-1:0]] <= wr_value;
        end
        if (adv)
        begin
            vec_rd_reg <= vec_mem[cnt_reg[VAW-1:0]];
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign tok  = tok_reg;
    assign vec  = vec_rd_reg;

endmodule

/* src/matrix_vector_multiply_unit.sv */
// a compute transaction sends one token per matrix row through the cell chain, followed in
// transposed mode by one readout token per column; tokens enter at one token a cycle while
// the chain advances, and no new transaction is accepted until the last result is taken
// load transactions complete in the accept cycle; output stalls freeze the whole chain
// reset: asynchronous active low; clears control, num_rows = num_cols = 64, transposed = 0
// matrix and vector stores are not cleared and hold garbage until written
module matrix_vector_multiply_unit #(
    parameter int MAX_ROWS    = mvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = mvm_pkg::MAX_COLS_DEF,
    parameter int VALUE_WIDTH = mvm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mvm_item_if.sink                        items,
    mvm_result_if.source                    results,
    input  logic                            write_enable,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]   reg_index,
    input  logic [mvm_pkg::CFG_W-1:0]       write_data
);
    import mvm_pkg::*;

    // configuration registers
    logic [DIM_W-1:0] num_rows_reg;
    logic [DIM_W-1:0] num_cols_reg;
    logic             transposed_reg;

    // effective dimensions, saturated to 1..MAX
    logic [DIM_W-1:0] nr_eff;
    logic [DIM_W-1:0] nc_eff;

    // handshake helpers
    logic             item_accept;
    logic             start;
    logic             done;
    logic             busy;
    logic             adv;

    // load bus
    mvm_wr_t          wr;

    // cell chain: index c + 1 feeds cell c, cell c drives index c
    mvm_tok_t                      tok_w [MAX_COLS + 1];
    logic signed [VALUE_WIDTH-1:0] vec_w [MAX_COLS + 1];
    logic signed [OUT_W-1:0]       sum_w [MAX_COLS + 1];

    // token delay matching cell 0's read, multiply and add stages
    mvm_tok_t          res1_reg;
    mvm_tok_t          res2_reg;
    mvm_tok_t          res3_reg;

    // output register
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic signed [OUT_W-1:0] out_value_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg   <= DIM_W'(64);
            num_cols_reg   <= DIM_W'(64);
            transposed_reg <= 1'b0;
        end
        else if (write_enable)
        begin
            case (reg_index)
                REG_NUM_ROWS:   num_rows_reg   <= write_data;
                REG_NUM_COLS:   num_cols_reg   <= write_data;
                REG_TRANSPOSED: transposed_reg <= write_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (num_rows_reg == '0)
            nr_eff = DIM_W'(1);
        else if (num_rows_reg > DIM_W'(MAX_ROWS))
            nr_eff = DIM_W'(MAX_ROWS);
        else
            nr_eff = num_rows_reg;

        if (num_cols_reg == '0)
            nc_eff = DIM_W'(1);
        else if (num_cols_reg > DIM_W'(MAX_COLS))
            nc_eff = DIM_W'(MAX_COLS);
        else
            nc_eff = num_cols_reg;
    end

    // only one transaction in flight; loads complete in the accept cycle
    assign items.ready = !busy;
    assign item_accept = items.valid && items.ready;
    assign start       = item_accept && (items.action == ACT_COMPUTE);
    assign done        = results.valid && results.ready && results.last;

    assign wr.mat_we = item_accept && (items.action == ACT_LOAD_MATRIX);
    assign wr.vec_we = item_accept && (items.action == ACT_LOAD_VECTOR);
    assign wr.row    = items.row;
    assign wr.col    = items.col;
    assign wr.vidx   = items.vector_index;

    // the chain moves whenever the output register can take a result
    assign adv = !out_valid_reg || results.ready;

    // issues row tokens, then in transposed mode one readout token per column
    mvm_seq #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .start       (start),
        .done        (done),
        .transposed  (transposed_reg),
        .nr_eff      (nr_eff),
        .nc_eff      (nc_eff),
        .wr          (wr),
        .wr_value    (items.value),
        .busy        (busy),
        .tok         (tok_w[MAX_COLS]),
        .vec         (vec_w[MAX_COLS])
    );

    // partial sums start at zero at the far end of the chain
    assign sum_w[MAX_COLS] = '0;

    // one cell per matrix column; tokens and partial sums move one cell per cycle toward
    // cell 0 while the chain advances, so a row's dot product leaves cell 0 complete
    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_cell
        mvm_cell #(
            .MAX_ROWS    (MAX_ROWS),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (c)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .nc_eff   (nc_eff),
            .wr       (wr),
            .wr_value (items.value),
            .tok_in   (tok_w[c + 1]),
            .vec_in   (vec_w[c + 1]),
            .sum_in   (sum_w[c + 1]),
            .tok_out  (tok_w[c]),
            .vec_out  (vec_w[c]),
            .sum_out  (sum_w[c])
        );
    end

    // line up cell 0's token with the sum it produced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res1_reg <= '0;
            res2_reg <= '0;
            res3_reg <= '0;
        end
        else if (adv)
        begin
            res1_reg <= tok_w[0];
            res2_reg <= res1_reg;
            res3_reg <= res2_reg;
        end
    end

    // row passes of transposed mode only accumulate and give no result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res3_reg.valid && !res3_reg.accum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_index_reg <= res3_reg.idx;
            out_value_reg <= sum_w[0];
            out_last_reg  <= res3_reg.last;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_index = out_index_reg;
    assign results.out_value = out_value_reg;
    assign results.last      = out_last_reg;

endmodule
